// ===== rtl/core/cfd_pkg.sv =====
`timescale 1ns / 1ps

package cfd_pkg;

    localparam int unsigned TRAILER_MAX = 3;
    localparam int unsigned MIN_FRAME   = 7;
    localparam int unsigned POS_W       = 17;
    localparam int unsigned SIZE_W      = POS_W + 1;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SECOND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD   = 2'd2;

    localparam logic [7:0]  HEADER_FIRST_RESET  = 8'd90;
    localparam logic [7:0]  HEADER_SECOND_RESET = 8'd51;
    localparam logic [15:0] MAX_PAYLOAD_RESET   = 16'd4096;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT        = 3'd1,
        ST_HEADER       = 3'd2,
        ST_TOO_LONG     = 3'd3,
        ST_TRUNCATED    = 3'd4,
        ST_TRAILER_LONG = 3'd5,
        ST_TRAILER_NZ   = 3'd6,
        ST_CHECKSUM     = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        CLS_HDR0,
        CLS_HDR1,
        CLS_CMD,
        CLS_LEN_HI,
        CLS_LEN_LO,
        CLS_PAYLOAD,
        CLS_CK_HI,
        CLS_CK_LO,
        CLS_TRAILER
    } byte_class_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic [7:0]  command_code;
        logic [15:0] payload_length;
        logic        frame_done;
        logic [2:0]  status;
    } out_item_t;

    typedef struct packed {
        logic short_frame;
        logic too_long;
        logic truncated;
        logic trailer_long;
    } size_flags_t;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic        last_byte;
        byte_class_t cls;
        logic        header_mismatch;
        size_flags_t flags;
        logic [15:0] length;
    } queue_entry_t;

endpackage

// ===== rtl/core/cfd_front.sv =====
`timescale 1ns / 1ps

module cfd_front
    import cfd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   push_valid,
    input  logic                   push_ready,
    output queue_entry_t           push_entry
);

    logic [7:0]       header_first_reg;
    logic [7:0]       header_second_reg;
    logic [15:0]      max_payload_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      len_reg, len_next;

    logic [SIZE_W-1:0] pos_ext;
    logic [SIZE_W-1:0] ck_pos;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] need;
    logic [SIZE_W-1:0] excess;
    byte_class_t       cls;
    logic              accept;

    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;

    assign pos_ext = {1'b0, pos_reg};
    assign ck_pos  = SIZE_W'(len_reg) + SIZE_W'(5);

    always_comb begin
        len_next = len_reg;
        if (pos_reg == POS_W'(0)) begin
            cls = CLS_HDR0;
        end else if (pos_reg == POS_W'(1)) begin
            cls = CLS_HDR1;
        end else if (pos_reg == POS_W'(2)) begin
            cls = CLS_CMD;
        end else if (pos_reg == POS_W'(3)) begin
            cls      = CLS_LEN_HI;
            len_next = {s_data.rx_byte, 8'h00};
        end else if (pos_reg == POS_W'(4)) begin
            cls      = CLS_LEN_LO;
            len_next = {len_reg[15:8], s_data.rx_byte};
        end else if (pos_ext < ck_pos) begin
            cls = CLS_PAYLOAD;
        end else if (pos_ext == ck_pos) begin
            cls = CLS_CK_HI;
        end else if (pos_ext == ck_pos + SIZE_W'(1)) begin
            cls = CLS_CK_LO;
        end else begin
            cls = CLS_TRAILER;
        end
    end

    assign size   = pos_ext + SIZE_W'(1);
    assign need   = SIZE_W'(len_next) + SIZE_W'(MIN_FRAME);
    assign excess = size - need;

    always_comb begin
        push_entry.rx_byte            = s_data.rx_byte;
        push_entry.last_byte          = s_data.last_byte;
        push_entry.cls                = cls;
        push_entry.length             = len_next;
        push_entry.header_mismatch    =
            ((cls == CLS_HDR0) && (s_data.rx_byte != header_first_reg)) ||
            ((cls == CLS_HDR1) && (s_data.rx_byte != header_second_reg));
        push_entry.flags.short_frame  = size < SIZE_W'(MIN_FRAME);
        push_entry.flags.too_long     = len_next > max_payload_reg;
        push_entry.flags.truncated    = size < need;
        push_entry.flags.trailer_long = excess > SIZE_W'(TRAILER_MAX);
    end

    assign push_valid = s_valid;

    always_comb begin
        if (s_data.last_byte) begin
            pos_next = '0;
        end else if (pos_reg != POS_MAX) begin
            pos_next = pos_reg + POS_W'(1);
        end else begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_first_reg  <= HEADER_FIRST_RESET;
            header_second_reg <= HEADER_SECOND_RESET;
            max_payload_reg   <= MAX_PAYLOAD_RESET;
            pos_reg           <= '0;
            len_reg           <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_HEADER_FIRST:  header_first_reg  <= cfg_data[7:0];
                    REG_HEADER_SECOND: header_second_reg <= cfg_data[7:0];
                    REG_MAX_PAYLOAD:   max_payload_reg   <= cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                pos_reg <= pos_next;
                len_reg <= s_data.last_byte ? 16'h0000 : len_next;
            end
        end
    end

endmodule

// ===== rtl/core/cfd_queue.sv =====
`timescale 1ns / 1ps

module cfd_queue
    import cfd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    output logic         push_ready,
    input  queue_entry_t push_entry,
    output logic         pop_valid,
    input  logic         pop_ready,
    output queue_entry_t pop_entry
);

    queue_entry_t      store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] ptr);
        if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return ptr + QPTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/cfd_back.sv =====
`timescale 1ns / 1ps

module cfd_back
    import cfd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         pop_valid,
    output logic         pop_ready,
    input  queue_entry_t pop_entry,
    output logic         m_valid,
    input  logic         m_ready,
    output out_item_t    m_data
);

    logic        header_error_reg, header_error_next;
    logic [7:0]  command_reg, command_next;
    logic [15:0] sum_reg, sum_next;
    logic [15:0] checksum_reg, checksum_next;
    logic        trailer_nz_reg, trailer_nz_next;
    logic        m_valid_reg;
    out_item_t   m_data_reg, m_data_next;
    status_t     status;
    logic        is_payload;
    logic        take;

    assign pop_ready = !m_valid_reg || m_ready;
    assign take      = pop_valid && pop_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        header_error_next = header_error_reg;
        command_next      = command_reg;
        sum_next          = sum_reg;
        checksum_next     = checksum_reg;
        trailer_nz_next   = trailer_nz_reg;
        is_payload        = 1'b0;
        unique case (pop_entry.cls)
            CLS_HDR0: header_error_next = pop_entry.header_mismatch;
            CLS_HDR1: header_error_next = header_error_reg | pop_entry.header_mismatch;
            CLS_CMD: begin
                command_next = pop_entry.rx_byte;
                sum_next     = {8'h00, pop_entry.rx_byte};
            end
            CLS_LEN_HI, CLS_LEN_LO: sum_next = sum_reg + 16'(pop_entry.rx_byte);
            CLS_PAYLOAD: begin
                is_payload = 1'b1;
                sum_next   = sum_reg + 16'(pop_entry.rx_byte);
            end
            CLS_CK_HI: checksum_next = {pop_entry.rx_byte, 8'h00};
            CLS_CK_LO: checksum_next = {checksum_reg[15:8], pop_entry.rx_byte};
            CLS_TRAILER: trailer_nz_next = trailer_nz_reg | (pop_entry.rx_byte != 8'h00);
            default: begin
            end
        endcase
    end

    always_comb begin
        if (!pop_entry.last_byte) begin
            status = ST_OK;
        end else if (pop_entry.flags.short_frame) begin
            status = ST_SHORT;
        end else if (header_error_next) begin
            status = ST_HEADER;
        end else if (pop_entry.flags.too_long) begin
            status = ST_TOO_LONG;
        end else if (pop_entry.flags.truncated) begin
            status = ST_TRUNCATED;
        end else if (pop_entry.flags.trailer_long) begin
            status = ST_TRAILER_LONG;
        end else if (trailer_nz_next) begin
            status = ST_TRAILER_NZ;
        end else if (sum_next != checksum_next) begin
            status = ST_CHECKSUM;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        m_data_next.payload_byte   = is_payload ? pop_entry.rx_byte : 8'h00;
        m_data_next.payload_valid  = is_payload;
        m_data_next.command_code   = command_next;
        m_data_next.payload_length = pop_entry.length;
        m_data_next.frame_done     = pop_entry.last_byte;
        m_data_next.status         = status;
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg      <= 1'b0;
            header_error_reg <= 1'b0;
            command_reg      <= '0;
            sum_reg          <= '0;
            checksum_reg     <= '0;
            trailer_nz_reg   <= 1'b0;
        end else begin
            if (take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (take) begin
                if (pop_entry.last_byte) begin
                    header_error_reg <= 1'b0;
                    command_reg      <= '0;
                    sum_reg          <= '0;
                    checksum_reg     <= '0;
                    trailer_nz_reg   <= 1'b0;
                end else begin
                    header_error_reg <= header_error_next;
                    command_reg      <= command_next;
                    sum_reg          <= sum_next;
                    checksum_reg     <= checksum_next;
                    trailer_nz_reg   <= trailer_nz_next;
                end
            end
        end
    end

endmodule

// ===== rtl/core/command_frame_deframer.sv =====
`timescale 1ns / 1ps

// Checks received command frames one byte per request and returns one result
// per byte, sustaining one byte per clock cycle while m_ready is not held low; each
// result passes through the two-entry queue, which takes the classified byte at
// the accepting edge, and then through the output register of the checking
// back stage. Payload bytes are passed on tentatively, and the result for the
// byte flagged as last carries the frame status. Configuration writes take effect
// at once and must only be made while no frame is in progress.
module command_frame_deframer
    import cfd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic         push_valid;
    logic         push_ready;
    queue_entry_t push_entry;
    logic         pop_valid;
    logic         pop_ready;
    queue_entry_t pop_entry;

    cfd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    cfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    cfd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import cfd_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned WATCHDOG_LIMIT  = 5000;
    localparam int unsigned IDLE_PERCENT    = 14;

    typedef enum int {
        FLAW_HEADER,
        FLAW_CHECKSUM,
        FLAW_TRAILER_BYTE,
        FLAW_EXTRA_ZEROS,
        FLAW_LENGTH,
        FLAW_TRUNCATE,
        FLAW_SHORT
    } flaw_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Shadow copy of the registers and of the frame being received.
    logic [7:0]       cfg_hdr_first;
    logic [7:0]       cfg_hdr_second;
    logic [15:0]      cfg_max_payload;
    logic [POS_W-1:0] frame_pos;
    logic             hdr_bad;
    logic [7:0]       cmd_seen;
    logic [15:0]      len_seen;
    logic [15:0]      sum_calc;
    logic [15:0]      sum_rx;
    logic             trailer_dirty;

    out_item_t   pending_results[$];
    logic [7:0]  frame_buf[$];
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    int unsigned bytes_sent = 0;
    int unsigned frames_sent = 0;
    int unsigned results_checked = 0;
    int unsigned error_count = 0;
    int unsigned stuck_cycles = 0;
    int unsigned status_seen[8];

    command_frame_deframer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_frame_state();
        frame_pos     = '0;
        hdr_bad       = 1'b0;
        cmd_seen      = 8'h00;
        len_seen      = 16'h0000;
        sum_calc      = 16'h0000;
        sum_rx        = 16'h0000;
        trailer_dirty = 1'b0;
    endfunction

    function automatic void deframe_byte(input in_item_t item);
        out_item_t   res;
        int unsigned pos;
        int unsigned ck_pos;
        int unsigned frame_len;
        int unsigned needed;
        logic [7:0]  b;
        status_t     st;
        b   = item.rx_byte;
        pos = frame_pos;
        res = '0;
        st  = ST_OK;
        case (pos)
            0: hdr_bad = (b != cfg_hdr_first);
            1: if (b != cfg_hdr_second) hdr_bad = 1'b1;
            2: begin
                cmd_seen = b;
                sum_calc = {8'h00, b};
            end
            3: begin
                len_seen = {b, 8'h00};
                sum_calc = sum_calc + b;
            end
            4: begin
                len_seen[7:0] = b;
                sum_calc = sum_calc + b;
            end
            default: begin
                ck_pos = 5 + len_seen;
                if (pos < ck_pos) begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = b;
                    sum_calc = sum_calc + b;
                end else if (pos == ck_pos) begin
                    sum_rx = {b, 8'h00};
                end else if (pos == ck_pos + 1) begin
                    sum_rx[7:0] = b;
                end else if (b != 8'h00) begin
                    trailer_dirty = 1'b1;
                end
            end
        endcase
        if (frame_pos != POS_MAX) frame_pos = frame_pos + 1'b1;
        res.command_code   = cmd_seen;
        res.payload_length = len_seen;
        res.frame_done     = item.last_byte;
        if (item.last_byte) begin
            frame_len = pos + 1;
            needed    = MIN_FRAME + len_seen;
            if (frame_len < MIN_FRAME) st = ST_SHORT;
            else if (hdr_bad) st = ST_HEADER;
            else if (len_seen > cfg_max_payload) st = ST_TOO_LONG;
            else if (frame_len < needed) st = ST_TRUNCATED;
            else if (frame_len - needed > TRAILER_MAX) st = ST_TRAILER_LONG;
            else if (trailer_dirty) st = ST_TRAILER_NZ;
            else if (sum_calc != sum_rx) st = ST_CHECKSUM;
            res.status = st;
            clear_frame_state();
        end
        pending_results.push_back(res);
    endfunction

    function automatic void check_result(input out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0) begin
            $error("result arrived with no byte outstanding");
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (want.frame_done) status_seen[want.status]++;
        if (got.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0d, got %0d", want.payload_byte, got.payload_byte);
            error_count++;
        end
        if (got.payload_valid !== want.payload_valid) begin
            $error("payload_valid: expected %0d, got %0d", want.payload_valid,
                   got.payload_valid);
            error_count++;
        end
        if (got.command_code !== want.command_code) begin
            $error("command_code: expected %0d, got %0d", want.command_code, got.command_code);
            error_count++;
        end
        if (got.payload_length !== want.payload_length) begin
            $error("payload_length: expected %0d, got %0d", want.payload_length,
                   got.payload_length);
            error_count++;
        end
        if (got.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
            error_count++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= stalls_on ? ($urandom_range(0, 99) >= IDLE_PERCENT) : 1'b1;
            if (m_valid && m_ready) check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
                stuck_cycles <= 0;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $error("no request accepted for %0d cycles", stuck_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // A request stays on the bus, unchanged, until the block accepts it.
    task automatic send_frame_byte(input logic [7:0] b, input bit last);
        in_item_t item;
        item.rx_byte   = b;
        item.last_byte = last;
        if (gaps_on) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        deframe_byte(item);
        bytes_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_HEADER_FIRST:  cfg_hdr_first = val[7:0];
            REG_HEADER_SECOND: cfg_hdr_second = val[7:0];
            REG_MAX_PAYLOAD:   cfg_max_payload = val;
            default: ;
        endcase
    endtask

    task automatic build_frame(input logic [7:0] cmd, input int unsigned plen,
                               input int unsigned ntrail);
        logic [15:0] len16;
        logic [15:0] sum;
        logic [7:0]  b;
        len16 = plen[15:0];
        sum   = cmd + len16[15:8] + len16[7:0];
        frame_buf.delete();
        frame_buf.push_back(cfg_hdr_first);
        frame_buf.push_back(cfg_hdr_second);
        frame_buf.push_back(cmd);
        frame_buf.push_back(len16[15:8]);
        frame_buf.push_back(len16[7:0]);
        repeat (plen) begin
            b = 8'($urandom);
            frame_buf.push_back(b);
            sum = sum + b;
        end
        frame_buf.push_back(sum[15:8]);
        frame_buf.push_back(sum[7:0]);
        repeat (ntrail) frame_buf.push_back(8'h00);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++) begin
            send_frame_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
        frames_sent++;
    endtask

    task automatic trim_frame(input int unsigned keep);
        while (frame_buf.size() > keep) frame_buf.pop_back();
    endtask

    task automatic test_default_frames();
        build_frame(8'h00, 0, 0);
        send_frame();
        build_frame(8'hFF, 2, TRAILER_MAX);
        frame_buf[5] = 8'hFF;
        frame_buf[6] = 8'h00;
        frame_buf[7] = 8'h02;
        frame_buf[8] = 8'h00;
        send_frame();
    endtask

    task automatic test_short_frames();
        for (int n = 1; n < MIN_FRAME; n++) begin
            build_frame(8'h3C, 0, 0);
            trim_frame(n);
            if (n % 2 == 1) frame_buf[0] = ~cfg_hdr_first;
            send_frame();
        end
    endtask

    task automatic test_status_priority();
        build_frame(8'h11, 2, 0);
        frame_buf[0] = frame_buf[0] ^ 8'h01;
        send_frame();
        build_frame(8'h12, 2, 1);
        frame_buf[1] = frame_buf[1] ^ 8'h80;
        send_frame();
        build_frame(8'h13, 0, 0);
        frame_buf[1] = ~frame_buf[1];
        frame_buf[3] = 8'hFF;
        send_frame();
        build_frame(8'h14, 0, 0);
        frame_buf[3] = 8'h10;
        frame_buf[4] = 8'h01;
        send_frame();
        build_frame(8'h15, 6, 0);
        trim_frame(10);
        send_frame();
        build_frame(8'h16, 1, TRAILER_MAX);
        frame_buf.push_back(8'h00);
        send_frame();
        build_frame(8'h17, 1, 2);
        frame_buf[frame_buf.size() - 1] = 8'h80;
        send_frame();
        build_frame(8'h18, 3, 1);
        frame_buf[9] = frame_buf[9] ^ 8'h01;
        send_frame();
    endtask

    task automatic test_register_writes();
        write_reg(REG_HEADER_FIRST, 16'hC300);
        write_reg(REG_HEADER_SECOND, 16'h12FF);
        write_reg(REG_MAX_PAYLOAD, 16'h0000);
        build_frame(8'h21, 0, 0);
        send_frame();
        build_frame(8'h22, 1, 0);
        send_frame();
        write_reg(REG_MAX_PAYLOAD, 16'hFFFF);
        build_frame(8'h23, 0, 0);
        frame_buf[3] = 8'hFF;
        frame_buf[4] = 8'hFF;
        frame_buf.push_back(8'h55);
        send_frame();
        build_frame(8'h24, 1, 0);
        frame_buf[0] = HEADER_FIRST_RESET;
        send_frame();
        write_reg(REG_UNUSED, 16'h0000);
        build_frame(8'h25, 3, 0);
        send_frame();
    endtask

    task automatic send_random_frame();
        int unsigned plen;
        int unsigned keep;
        flaw_t       flaw;
        keep = 0;
        if ($urandom_range(0, 9) == 0) begin
            frame_buf.delete();
            repeat ($urandom_range(1, 24)) frame_buf.push_back(8'($urandom));
            if ($urandom_range(0, 1) == 1) begin
                frame_buf[0] = cfg_hdr_first;
                if (frame_buf.size() > 1) frame_buf[1] = cfg_hdr_second;
            end
        end else begin
            if ($urandom_range(0, 19) == 0) plen = $urandom_range(17, 300);
            else plen = $urandom_range(0, 16);
            build_frame(8'($urandom), plen, $urandom_range(0, TRAILER_MAX));
            if ($urandom_range(0, 9) < 4) begin
                flaw = flaw_t'($urandom_range(FLAW_HEADER, FLAW_SHORT));
                case (flaw)
                    FLAW_HEADER:
                        frame_buf[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
                    FLAW_CHECKSUM:
                        frame_buf[5 + plen + $urandom_range(0, 1)] ^=
                            8'(1 << $urandom_range(0, 7));
                    FLAW_TRAILER_BYTE:
                        frame_buf.push_back(8'($urandom_range(1, 255)));
                    FLAW_EXTRA_ZEROS:
                        repeat ($urandom_range(1, 4)) frame_buf.push_back(8'h00);
                    FLAW_LENGTH:
                        frame_buf[3 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
                    FLAW_TRUNCATE:
                        keep = $urandom_range(1, frame_buf.size() - 1);
                    FLAW_SHORT:
                        keep = $urandom_range(1, MIN_FRAME - 1);
                    default: ;
                endcase
                if (keep != 0) trim_frame(keep);
            end
        end
        send_frame();
    endtask

    task automatic run_random_phase(input logic [15:0] h_first, input logic [15:0] h_second,
                                    input logic [15:0] max_len, input int unsigned budget,
                                    input bit idling);
        int unsigned start;
        write_reg(REG_HEADER_FIRST, h_first);
        write_reg(REG_HEADER_SECOND, h_second);
        write_reg(REG_MAX_PAYLOAD, max_len);
        gaps_on   = idling;
        stalls_on = idling;
        start     = bytes_sent;
        while (bytes_sent - start < budget) begin
            if ($urandom_range(0, 11) == 0) drain_results();
            send_random_frame();
        end
        drain_results();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        run_random_phase(16'hAB00, 16'h00FF, 16'hFFFF, 200, 1'b1);
        run_random_phase(16'($urandom), 16'($urandom), 16'($urandom_range(4, 24)), 200, 1'b0);
        run_random_phase(HEADER_FIRST_RESET, HEADER_SECOND_RESET, MAX_PAYLOAD_RESET, 150, 1'b1);
        run_random_phase(16'h00FF, 16'h0000, 16'h0000, 100, 1'b1);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cfg_hdr_first   = HEADER_FIRST_RESET;
        cfg_hdr_second  = HEADER_SECOND_RESET;
        cfg_max_payload = MAX_PAYLOAD_RESET;
        clear_frame_state();
        foreach (status_seen[i]) status_seen[i] = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_default_frames();
        test_short_frames();
        test_status_priority();
        test_register_writes();
        test_random_traffic();
        drain_results();

        $display("Checked %0d results for %0d bytes in %0d frames, %s",
                 results_checked, bytes_sent, frames_sent,
                 "with random idling on both sides and one stretch without.");
        $display("Final statuses: ok %0d, short %0d, header %0d, too long %0d, %s %0d,",
                 status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_HEADER],
                 status_seen[ST_TOO_LONG], "truncated", status_seen[ST_TRUNCATED]);
        $display("trailer long %0d, trailer nonzero %0d, checksum %0d.",
                 status_seen[ST_TRAILER_LONG], status_seen[ST_TRAILER_NZ],
                 status_seen[ST_CHECKSUM]);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
